// File: hdl/ptc_pkg.sv
// shared types and constants for the pressure and temperature compensation block
`default_nettype none
package ptc_pkg;

    localparam int RAW_W   = 20;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFFS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_NINE  = 8'd3;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] RAW_FULL    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] P1_BIAS     = 64'h0000_8000_0000_0000;

    // sequencer steps, temperature then pressure
    typedef enum logic [3:0] {
        ST_T_D1    = 4'd0,
        ST_T_D2SQ  = 4'd1,
        ST_T_T3    = 4'd2,
        ST_T_OUT   = 4'd3,
        ST_P_AA    = 4'd4,
        ST_P_P6    = 4'd5,
        ST_P_P5    = 4'd6,
        ST_P_P3    = 4'd7,
        ST_P_P2    = 4'd8,
        ST_P_P1    = 4'd9,
        ST_P_NUM   = 4'd10,
        ST_P_DIV   = 4'd11,
        ST_P_P9A   = 4'd12,
        ST_P_P9B   = 4'd13,
        ST_P_P8    = 4'd14,
        ST_P_OUT   = 4'd15
    } step_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_MUL   = 4'b0100,
        S_DIV   = 4'b1000
    } state_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

// File: hdl/pressure_temperature_compensation.sv
// pressure and temperature compensation with a radix-16 serial multiplier and radix-2 divider
//
// channel  | handshake              | payload
// s_       | s_tvalid / s_tready    | s_tuser: cmd; s_tdata: raw_sample
// m_       | m_tvalid / m_tready    | m_tuser: result_kind, divide_by_zero; m_tdata: temp, press
// cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// each multiply is a setup step and 16 four-bit digits, the divide a setup step and 64 bits
// temperature item: three multiplies; pressure item: ten multiplies and one divide,
// ending before the numerator multiply when the divisor is zero
// one item is in work at a time; the result register frees the input while it waits
// reset clears coefficients, fine temperature and all control state
`default_nettype none
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // raw_sample, zero pad
    input  wire logic                 s_tuser,   // cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata,   // temperature_centi, pressure_q24_8
    output logic [1:0]                m_tuser,   // result_kind, divide_by_zero
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic [47:0] tc_reg;
    logic [63:0] pl_reg, ph_reg;
    logic [15:0] p9_reg;
    logic [31:0] fine_reg, fine_next;
    logic [63:0] mcand_reg, mcand_next, mplier_reg, mplier_next, prod_reg, prod_next;
    logic [63:0] aa_reg, aa_next, b_reg, b_next, t_reg, t_next, den_reg, den_next;
    logic [63:0] p_reg, p_next;
    logic        neg_reg, neg_next;
    logic        ovalid_reg, ovalid_next;
    logic [63:0] odata_reg, odata_next;
    logic [1:0]  ouser_reg, ouser_next;

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, a_val;
    logic [31:0] d1, d2, v1, v2, fine_new, temp_c, fine5;
    logic [63:0] pp, prod_sum, rem_sh_lo, num_abs, den_abs, quo, p_sh13, press_fin;
    logic [64:0] rem_sh, rem_diff;
    logic        out_free;

    assign t1 = {48'd0, tc_reg[15:0]};
    assign t2 = sx16(tc_reg[31:16]);
    assign t3 = sx16(tc_reg[47:32]);
    assign p1 = {48'd0, pl_reg[15:0]};
    assign p2 = sx16(pl_reg[31:16]);
    assign p3 = sx16(pl_reg[47:32]);
    assign p4 = sx16(pl_reg[63:48]);
    assign p5 = sx16(ph_reg[15:0]);
    assign p6 = sx16(ph_reg[31:16]);
    assign p7 = sx16(ph_reg[47:32]);
    assign p8 = sx16(ph_reg[63:48]);
    assign p9 = sx16(p9_reg);

    assign a_val = {{32{fine_reg[31]}}, fine_reg} - FINE_OFFSET;
    assign d1 = 32'(raw_reg >> 3) - 32'({t1[15:0], 1'b0});
    assign d2 = 32'(raw_reg >> 4) - 32'(t1[15:0]);
    assign v1 = 32'($signed(t_reg[31:0]) >>> 11);
    assign v2 = 32'($signed(b_reg[31:0]) >>> 14);
    assign fine_new = v1 + v2;
    assign fine5 = fine_new + {fine_new[29:0], 2'b00} + 32'd128;
    assign temp_c = 32'($signed(fine5) >>> 8);
    assign p_sh13 = 64'($signed(p_reg) >>> 13);
    assign press_fin = 64'($signed(p_reg + t_reg + b_reg) >>> 8) + {p7[59:0], 4'd0};

    // one four-bit digit of the multiplier per cycle
    assign pp = (mplier_reg[0] ? mcand_reg : 64'd0)
              + (mplier_reg[1] ? {mcand_reg[62:0], 1'b0} : 64'd0)
              + (mplier_reg[2] ? {mcand_reg[61:0], 2'b0} : 64'd0)
              + (mplier_reg[3] ? {mcand_reg[60:0], 3'b0} : 64'd0);
    assign prod_sum = prod_reg + pp;

    // restoring divide step: remainder in prod, quotient shifts through mplier
    assign rem_sh = {prod_reg, mplier_reg[63]};
    assign rem_diff = rem_sh - {1'b0, mcand_reg};
    assign rem_sh_lo = rem_sh[63:0];
    assign quo = {mplier_reg[62:0], ~rem_diff[64]};
    assign num_abs = aa_reg[63] ? (64'd0 - aa_reg) : aa_reg;
    assign den_abs = den_reg[63] ? (64'd0 - den_reg) : den_reg;

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = odata_reg;
    assign m_tuser = ouser_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        raw_next = raw_reg;
        fine_next = fine_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        prod_next = prod_reg;
        aa_next = aa_reg;
        b_next = b_reg;
        t_next = t_reg;
        den_next = den_reg;
        p_next = p_reg;
        neg_next = neg_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next = odata_reg;
        ouser_next = ouser_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    raw_next = s_tdata[RAW_W-1:0];
                    step_next = (s_tuser == CMD_PRESS) ? ST_P_AA : ST_T_D1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_MUL;
                cnt_next = 6'd0;
                prod_next = 64'd0;
                case (step_reg)
                    ST_T_D1:
                    begin
                        mcand_next = {32'd0, d1};
                        mplier_next = t2;
                    end
                    ST_T_D2SQ:
                    begin
                        mcand_next = {32'd0, d2};
                        mplier_next = {32'd0, d2};
                    end
                    ST_T_T3:
                    begin
                        mcand_next = {32'd0, 32'($signed(aa_reg[31:0]) >>> 12)};
                        mplier_next = t3;
                    end
                    ST_T_OUT:
                    begin
                        state_next = S_SETUP;
                        if (out_free)
                        begin
                            fine_next = fine_new;
                            ovalid_next = 1'b1;
                            odata_next = {32'd0, temp_c};
                            ouser_next = {1'b0, CMD_TEMP};
                            state_next = S_IDLE;
                        end
                    end
                    ST_P_AA:
                    begin
                        mcand_next = a_val;
                        mplier_next = a_val;
                    end
                    ST_P_P6:
                    begin
                        mcand_next = aa_reg;
                        mplier_next = p6;
                    end
                    ST_P_P5:
                    begin
                        mcand_next = a_val;
                        mplier_next = p5;
                    end
                    ST_P_P3:
                    begin
                        mcand_next = aa_reg;
                        mplier_next = p3;
                    end
                    ST_P_P2:
                    begin
                        mcand_next = a_val;
                        mplier_next = p2;
                    end
                    ST_P_P1:
                    begin
                        mcand_next = P1_BIAS + t_reg;
                        mplier_next = p1;
                    end
                    ST_P_NUM:
                    begin
                        mcand_next = 64'({(RAW_FULL - 64'(raw_reg)), 31'd0}) - b_reg;
                        mplier_next = PRESS_SCALE;
                        if (den_reg == 64'd0)
                        begin
                            state_next = S_SETUP;
                            if (out_free)
                            begin
                                ovalid_next = 1'b1;
                                odata_next = 64'd0;
                                ouser_next = {1'b1, CMD_PRESS};
                                state_next = S_IDLE;
                            end
                        end
                    end
                    ST_P_DIV:
                    begin
                        mcand_next = den_abs;
                        mplier_next = num_abs;
                        neg_next = aa_reg[63] ^ den_reg[63];
                        state_next = S_DIV;
                    end
                    ST_P_P9A:
                    begin
                        mcand_next = p9;
                        mplier_next = p_sh13;
                    end
                    ST_P_P9B:
                    begin
                        mcand_next = t_reg;
                        mplier_next = p_sh13;
                    end
                    ST_P_P8:
                    begin
                        mcand_next = p8;
                        mplier_next = p_reg;
                    end
                    ST_P_OUT:
                    begin
                        state_next = S_SETUP;
                        if (out_free)
                        begin
                            ovalid_next = 1'b1;
                            odata_next = {press_fin[31:0], 32'd0};
                            ouser_next = {1'b0, CMD_PRESS};
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MUL:
            begin
                prod_next = prod_sum;
                mcand_next = {mcand_reg[59:0], 4'd0};
                mplier_next = {4'd0, mplier_reg[63:4]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'd15)
                begin
                    state_next = S_SETUP;
                    step_next = step_t'(step_reg + 4'd1);
                    case (step_reg)
                        ST_T_D1:   t_next = prod_sum;
                        ST_T_D2SQ: aa_next = prod_sum;
                        ST_T_T3:   b_next = prod_sum;
                        ST_P_AA:   aa_next = prod_sum;
                        ST_P_P6:   b_next = prod_sum;
                        ST_P_P5:   b_next = b_reg + {prod_sum[46:0], 17'd0}
                                          + {p4[28:0], 35'd0};
                        ST_P_P3:   t_next = prod_sum;
                        ST_P_P2:   t_next = 64'($signed(t_reg) >>> 8)
                                          + {prod_sum[51:0], 12'd0};
                        ST_P_P1:   den_next = 64'($signed(prod_sum) >>> 33);
                        ST_P_NUM:  aa_next = prod_sum;
                        ST_P_P9A:  t_next = prod_sum;
                        ST_P_P9B:  t_next = 64'($signed(prod_sum) >>> 25);
                        ST_P_P8:   b_next = 64'($signed(prod_sum) >>> 19);
                        default:   b_next = b_reg;
                    endcase
                end
            end
            S_DIV:
            begin
                prod_next = rem_diff[64] ? rem_sh_lo : rem_diff[63:0];
                mplier_next = quo;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    p_next = neg_reg ? (64'd0 - quo) : quo;
                    step_next = step_t'(step_reg + 4'd1);
                    state_next = S_SETUP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= ST_T_D1;
            cnt_reg <= 6'd0;
            ovalid_reg <= 1'b0;
            fine_reg <= 32'd0;
            tc_reg <= 48'd0;
            pl_reg <= 64'd0;
            ph_reg <= 64'd0;
            p9_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            cnt_reg <= cnt_next;
            ovalid_reg <= ovalid_next;
            fine_reg <= fine_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TEMP_COEFFS: tc_reg <= cfg_data[47:0];
                    CFG_PRESS_LOW:   pl_reg <= cfg_data;
                    CFG_PRESS_HIGH:  ph_reg <= cfg_data;
                    CFG_PRESS_NINE:  p9_reg <= cfg_data[15:0];
                    default:         p9_reg <= p9_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg <= prod_next;
        aa_reg <= aa_next;
        b_reg <= b_next;
        t_reg <= t_next;
        den_reg <= den_next;
        p_reg <= p_next;
        neg_reg <= neg_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[63:32] == 32'd0 && m_tuser[0] == CMD_PRESS)
        else $error("divide by zero result carries nonzero pressure");

    a_temp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == CMD_TEMP |-> m_tdata[63:32] == 32'd0 && !m_tuser[1])
        else $error("temperature result carries pressure fields");

    a_press_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == CMD_PRESS |-> m_tdata[31:0] == 32'd0)
        else $error("pressure result carries temperature");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_SETUP && !s_tready)
        else $error("sequencer did not start after input transfer");

    a_fine_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fine_reg) |-> $past(state_reg == S_SETUP && step_reg == ST_T_OUT))
        else $error("fine temperature changed outside a temperature result");

endmodule
`default_nettype wire

// File: test/tb_pressure_temperature_compensation.sv
// self-checking testbench for the pressure and temperature compensation block
`timescale 1ns / 1ps
`default_nettype none
module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] temp;
        logic [31:0] press;
        logic        dbz;
    } comp_result_t;

    // expected compensation results with the block's coefficient and fine temperature copy
    class comp_scoreboard;
        logic [47:0] tc;
        logic [63:0] pl, ph;
        logic [15:0] p9;
        logic [31:0] fine;
        comp_result_t pending[$];
        int errors;

        function new();
            tc = '0; pl = '0; ph = '0; p9 = '0; fine = '0; errors = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [63:0] v);
            case (idx)
                CFG_TEMP_COEFFS: tc = v[47:0];
                CFG_PRESS_LOW: pl = v;
                CFG_PRESS_HIGH: ph = v;
                CFG_PRESS_NINE: p9 = v[15:0];
                default: ;
            endcase
        endfunction

        function automatic logic [63:0] quot(logic [63:0] a, logic [63:0] b);
            logic [63:0] ua, ub, q;
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            q = ua / ub;
            return (a[63] != b[63]) ? -q : q;
        endfunction

        function void note_sample(logic cmd, logic [19:0] raw);
            comp_result_t r;
            logic signed [31:0] t1, t2, t3, d1, d2, v1, v2, f;
            logic signed [63:0] a, b, p, q1, q2, q3, q4, q5, q6, q7, q8, q9;
            r = '0;
            if (cmd == CMD_TEMP) begin
                t1 = {16'd0, tc[15:0]};
                t2 = {{16{tc[31]}}, tc[31:16]};
                t3 = {{16{tc[47]}}, tc[47:32]};
                d1 = {15'd0, raw[19:3]} - (t1 <<< 1);
                v1 = (d1 * t2) >>> 11;
                d2 = {16'd0, raw[19:4]} - t1;
                v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
                f = v1 + v2;
                fine = f;
                r.temp = (f * 5 + 128) >>> 8;
            end else begin
                q1 = {48'd0, pl[15:0]};
                q2 = 64'(signed'(pl[31:16])); q3 = 64'(signed'(pl[47:32]));
                q4 = 64'(signed'(pl[63:48])); q5 = 64'(signed'(ph[15:0]));
                q6 = 64'(signed'(ph[31:16])); q7 = 64'(signed'(ph[47:32]));
                q8 = 64'(signed'(ph[63:48])); q9 = 64'(signed'(p9));
                a = 64'(signed'(fine)) - 64'sd128000;
                b = a * a * q6;
                b = b + ((a * q5) <<< 17);
                b = b + (q4 <<< 35);
                a = ((a * a * q3) >>> 8) + ((a * q2) <<< 12);
                a = (((64'sd1 <<< 47) + a) * q1) >>> 33;
                r.kind = 1'b1;
                if (a == 0) r.dbz = 1'b1;
                else begin
                    p = 64'sd1048576 - {44'd0, raw};
                    p = quot(((p <<< 31) - b) * 64'sd3125, a);
                    a = (q9 * (p >>> 13) * (p >>> 13)) >>> 25;
                    b = (q8 * p) >>> 19;
                    p = ((p + a + b) >>> 8) + (q7 <<< 4);
                    r.press = p[31:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(comp_result_t got);
            comp_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind) begin
                $display("%0t: kind exp %b got %b", $realtime, e.kind, got.kind); errors++;
            end
            if (got.temp !== e.temp) begin
                $display("%0t: temp exp %h got %h", $realtime, e.temp, got.temp); errors++;
            end
            if (got.press !== e.press) begin
                $display("%0t: press exp %h got %h", $realtime, e.press, got.press); errors++;
            end
            if (got.dbz !== e.dbz) begin
                $display("%0t: dbz exp %b got %b", $realtime, e.dbz, got.dbz); errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic s_tvalid, s_tready, s_tuser;
    logic [23:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [63:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid, cfg_ready;
    logic [7:0] cfg_index;
    logic [63:0] cfg_data;
    int send_idle, recv_stall;
    comp_scoreboard sb;

    pressure_temperature_compensation uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result('{m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tuser[1]});
    end

    always @(negedge clk)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic write_reg(logic [7:0] idx, logic [63:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic cmd, logic [19:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'd0, raw};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_sample(cmd, raw);
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // typical calibration values with random jitter
    task automatic typical_coeffs();
        write_reg(CFG_TEMP_COEFFS, {16'(-($urandom_range(2000))), 16'(26000 + $urandom_range(2000)),
                                    16'(27000 + $urandom_range(2000))});
        write_reg(CFG_PRESS_LOW, {16'(2800 + $urandom_range(200)), 16'(-($urandom_range(5000))),
                                  16'(-(10000 + $urandom_range(2000))),
                                  16'(36000 + $urandom_range(2000))});
        write_reg(CFG_PRESS_HIGH, {16'(-(11000 + $urandom_range(2000))),
                                   16'(15000 + $urandom_range(1000)),
                                   16'(-($urandom_range(20))), 16'(140 + $urandom_range(20))});
        write_reg(CFG_PRESS_NINE, 64'(6000 + $urandom_range(1000)));
    endtask

    initial
    begin
        logic [63:0] r;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        send_idle = 0; recv_stall = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients: pressure before any temperature, zero divisor
        send_sample(CMD_PRESS, 20'h00000);
        send_sample(CMD_TEMP, 20'hFFFFF);
        send_sample(CMD_PRESS, 20'hFFFFF);
        drain();
        typical_coeffs();
        send_sample(CMD_PRESS, 20'h5A000);
        send_sample(CMD_TEMP, 20'h7E000);
        send_sample(CMD_PRESS, 20'h5A000);
        send_sample(CMD_TEMP, 20'h00000);
        send_sample(CMD_PRESS, 20'h00000);
        send_sample(CMD_TEMP, 20'hFFFFF);
        send_sample(CMD_PRESS, 20'hFFFFF);
        drain();
        // all ones and extreme coefficients, ignored index
        write_reg(CFG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PRESS_NINE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(8'd7, 64'h1234);
        send_sample(CMD_TEMP, 20'h80000);
        send_sample(CMD_PRESS, 20'h7FFFF);
        drain();
        write_reg(CFG_TEMP_COEFFS, 64'h8000_7FFF_FFFF);
        write_reg(CFG_PRESS_LOW, 64'h8000_7FFF_8000_FFFF);
        write_reg(CFG_PRESS_HIGH, 64'h7FFF_8000_7FFF_8000);
        write_reg(CFG_PRESS_NINE, 64'h8000);
        send_sample(CMD_TEMP, 20'h12345);
        send_sample(CMD_PRESS, 20'hEDCBA);
        send_sample(CMD_TEMP, 20'hFFFFF);
        send_sample(CMD_PRESS, 20'h00001);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 75; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 75; end
                default: begin send_idle = 16; recv_stall = 16; end
            endcase
            if (ph == 6) begin
                r = {$urandom, $urandom};
                write_reg(CFG_TEMP_COEFFS, r);
                write_reg(CFG_PRESS_LOW, {$urandom, $urandom});
                write_reg(CFG_PRESS_HIGH, {$urandom, $urandom});
                write_reg(CFG_PRESS_NINE, {$urandom, $urandom});
            end else typical_coeffs();
            for (int i = 0; i < 66; i++)
            begin
                if ($urandom_range(9) < 7)
                    send_sample(i % 2 ? CMD_PRESS : CMD_TEMP,
                                20'(($urandom_range(3) == 0) ? $urandom
                                    : 20'h50000 + $urandom_range(20'h40000)));
                else
                    send_sample(1'($urandom), 20'($urandom));
            end
            drain();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
